// File: sv/tlbl_pkg.sv
// Shared types and constants for the TLB lookup/insert core.
// No dependencies; imported by every module of the block except tlbl_ram.
`default_nettype none
package tlbl_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int VPN_BITS_DEF    = 20;
    localparam int PFN_BITS_DEF    = 20;

    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int QDEPTH = 2;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LK_CMP,
        S_LK_ENC,
        S_LK_RD,
        S_LK_OUT,
        S_IN_SEL,
        S_IN_MIN,
        S_IN_WR
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

// File: sv/tlbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tlbl_ram #(
    parameter int W     = 20,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH < 2) ? 1 : $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/tlbl_queue.sv
// Short word queue between the front and back ends.
// Depends on tlbl_pkg (queue depth, status struct).
`default_nettype none
module tlbl_queue #(
    parameter int W = 41
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [W-1:0]      push_data,
    input  wire logic              pop,
    output logic      [W-1:0]      pop_data,
    output tlbl_pkg::q_stat_t      stat
);
    import tlbl_pkg::*;

    localparam int PTR_W = (QDEPTH < 2) ? 1 : $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [W-1:0]     mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QDEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule
`default_nettype wire

// File: sv/tlbl_front.sv
// Front end: takes command words, classifies them and feeds the queue.
// Depends on tlbl_pkg.
`default_nettype none
module tlbl_front #(
    parameter int VPN_BITS = tlbl_pkg::VPN_BITS_DEF,
    parameter int PFN_BITS = tlbl_pkg::PFN_BITS_DEF,
    localparam int QW      = 1 + VPN_BITS + PFN_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                opcode,
    input  wire logic [VPN_BITS-1:0] virt_page,
    input  wire logic [PFN_BITS-1:0] phys_frame,
    input  wire tlbl_pkg::q_stat_t   q_stat,
    output logic                     push,
    output logic      [QW-1:0]       push_data
);
    import tlbl_pkg::*;

    logic                hold_reg;
    op_kind_t            kind_reg;
    logic [VPN_BITS-1:0] page_reg;
    logic [PFN_BITS-1:0] frame_reg;
    logic                accept;

    assign busy   = hold_reg && q_stat.full;
    assign accept = start && !busy;
    assign push   = hold_reg && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_reg <= 1'b0;
        end
    end

    // frame is meaningless for a lookup; zero it so the queue word is clean
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= op_kind_t'(opcode);
            page_reg  <= virt_page;
            frame_reg <= (op_kind_t'(opcode) == OP_INSERT) ? phys_frame : '0;
        end
    end

    assign push_data = {kind_reg, page_reg, frame_reg};

endmodule
`default_nettype wire

// File: sv/tlbl_back.sv
// Back end: tag compare, LRU victim search, entry update and result register.
// Depends on tlbl_pkg and tlbl_ram (frame store).
`default_nettype none
module tlbl_back #(
    parameter int TLB_ENTRIES = tlbl_pkg::TLB_ENTRIES_DEF,
    parameter int VPN_BITS    = tlbl_pkg::VPN_BITS_DEF,
    parameter int PFN_BITS    = tlbl_pkg::PFN_BITS_DEF,
    localparam int QW         = 1 + VPN_BITS + PFN_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [QW-1:0]           q_data,
    input  wire tlbl_pkg::q_stat_t       q_stat,
    output logic                         pop,
    output logic                         done,
    output logic                         hit,
    output logic [PFN_BITS-1:0]          frame_out,
    output logic [tlbl_pkg::SLOT_W-1:0]  slot_used
);
    import tlbl_pkg::*;

    localparam int N      = TLB_ENTRIES;
    localparam int LEVELS = $clog2(N);
    localparam int NPOW   = 1 << LEVELS;
    localparam int IDX_W  = (LEVELS < 1) ? 1 : LEVELS;
    localparam int LVL_W  = (LEVELS < 1) ? 1 : $clog2(LEVELS + 1);

    back_state_t state_reg, state_next;

    // entry storage
    logic [N-1:0]        valid_reg;
    logic [VPN_BITS-1:0] page_reg  [N];
    logic [COUNT_W-1:0]  stamp_reg [N];
    logic [COUNT_W-1:0]  count_reg;

    // current word
    op_kind_t            kind_reg;
    logic [VPN_BITS-1:0] vpn_reg;
    logic [PFN_BITS-1:0] pfn_reg;

    logic [N-1:0]        match_reg;
    logic                hit_flag_reg;
    logic [IDX_W-1:0]    idx_reg;

    // min-stamp reduction tree, reduced in place one level per cycle
    logic [COUNT_W-1:0]  tree_val_reg [NPOW];
    logic [IDX_W-1:0]    tree_idx_reg [NPOW];
    logic [LVL_W-1:0]    lvl_reg;

    logic                done_reg;
    logic                hit_o_reg;
    logic [PFN_BITS-1:0] frame_o_reg;
    logic [SLOT_W-1:0]   slot_o_reg;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [PFN_BITS-1:0] ram_rdata;

    logic [N-1:0]        match_vec;
    logic [IDX_W-1:0]    match_idx;
    logic                any_match;
    logic [IDX_W-1:0]    free_idx;
    logic                all_valid;
    logic                tree_done;
    logic [SLOT_W-1:0]   idx_slot;
    logic [IDX_W+SLOT_W-1:0] idx_ext;

    tlbl_ram #(
        .W     (PFN_BITS),
        .DEPTH (N)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (pfn_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match_vec[i] = valid_reg[i] && (page_reg[i] == vpn_reg);
        end
    end

    // lowest set index wins
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_match = |match_reg;
    assign all_valid = &valid_reg;
    assign tree_done = (lvl_reg == LVL_W'(LEVELS));
    assign idx_ext   = {{SLOT_W{1'b0}}, idx_reg};
    assign idx_slot  = idx_ext[SLOT_W-1:0];
    assign ram_raddr = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (op_kind_t'(q_data[QW-1]) == OP_INSERT)
                    begin
                        state_next = S_IN_SEL;
                    end
                    else
                    begin
                        state_next = S_LK_CMP;
                    end
                end
            end
            S_LK_CMP: state_next = S_LK_ENC;
            S_LK_ENC: state_next = S_LK_RD;
            S_LK_RD:  state_next = S_LK_OUT;
            S_LK_OUT: state_next = S_IDLE;
            S_IN_SEL:
            begin
                state_next = all_valid ? S_IN_MIN : S_IN_WR;
            end
            S_IN_MIN:
            begin
                if (tree_done)
                begin
                    state_next = S_IN_WR;
                end
            end
            S_IN_WR:
            begin
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_LK_OUT) || (state_reg == S_IN_WR);
            if (state_reg == S_LK_CMP && count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (state_reg == S_IN_WR)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                kind_reg <= op_kind_t'(q_data[QW-1]);
                vpn_reg  <= q_data[QW-2:PFN_BITS];
                pfn_reg  <= q_data[PFN_BITS-1:0];
            end
            S_LK_CMP:
            begin
                match_reg <= match_vec;
            end
            S_LK_ENC:
            begin
                hit_flag_reg <= any_match;
                idx_reg      <= match_idx;
            end
            S_LK_RD:
            begin
                if (hit_flag_reg)
                begin
                    stamp_reg[idx_reg] <= count_reg;
                end
            end
            S_LK_OUT:
            begin
                hit_o_reg   <= hit_flag_reg;
                frame_o_reg <= hit_flag_reg ? ram_rdata : '0;
                slot_o_reg  <= hit_flag_reg ? idx_slot : '0;
            end
            S_IN_SEL:
            begin
                idx_reg <= free_idx;
                lvl_reg <= '0;
                for (int i = 0; i < NPOW; i++)
                begin
                    if (i < N)
                    begin
                        tree_val_reg[i] <= stamp_reg[i];
                    end
                    else
                    begin
                        tree_val_reg[i] <= COUNT_MAX;
                    end
                    tree_idx_reg[i] <= IDX_W'(i);
                end
            end
            S_IN_MIN:
            begin
                if (tree_done)
                begin
                    idx_reg <= tree_idx_reg[0];
                end
                else
                begin
                    lvl_reg <= lvl_reg + LVL_W'(1);
                    // left operand has the lower index, so it wins ties
                    for (int i = 0; i < NPOW / 2; i++)
                    begin
                        if (tree_val_reg[2*i+1] < tree_val_reg[2*i])
                        begin
                            tree_val_reg[i] <= tree_val_reg[2*i+1];
                            tree_idx_reg[i] <= tree_idx_reg[2*i+1];
                        end
                        else
                        begin
                            tree_val_reg[i] <= tree_val_reg[2*i];
                            tree_idx_reg[i] <= tree_idx_reg[2*i];
                        end
                    end
                end
            end
            S_IN_WR:
            begin
                page_reg[idx_reg]  <= vpn_reg;
                stamp_reg[idx_reg] <= count_reg;
                hit_o_reg          <= 1'b0;
                frame_o_reg        <= '0;
                slot_o_reg         <= idx_slot;
            end
            default:
            begin
                lvl_reg <= lvl_reg;
            end
        endcase
    end

    assign done      = done_reg;
    assign hit       = hit_o_reg;
    assign frame_out = frame_o_reg;
    assign slot_used = slot_o_reg;

`ifndef SYNTHESIS
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_LK_OUT || $past(state_reg) == S_IN_WR))
        else $error("result strobe without a finishing state");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_count_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_LK_CMP))
        else $error("access counter moved outside a lookup");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(valid_reg) & ~valid_reg) == '0))
        else $error("entry lost its valid bit");

    a_insert_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IN_WR) |-> (kind_reg == OP_INSERT))
        else $error("entry write for a lookup word");
`endif

endmodule
`default_nettype wire

// File: sv/tlb_lru_lookup_insert_core.sv
// Top level of the fully associative TLB with timestamp LRU replacement.
// Depends on tlbl_pkg, tlbl_front, tlbl_queue, tlbl_back, tlbl_ram.
//
// A word is taken when start is high and busy is low; each word gives exactly one
// result, shown for one cycle with done high, in order, and the receiver cannot stall
// it. Words pass through an input register and a two-word queue to the back end,
// which handles one at a time: a lookup steps through compare, encode, frame RAM
// read and output; an insert into a free slot selects and writes the slot, and an
// insert into a full table also runs the min-stamp tree (one level per cycle) to
// find the victim. busy rises only when the front register and the queue are full.
`default_nettype none
module tlb_lru_lookup_insert_core #(
    parameter int TLB_ENTRIES = tlbl_pkg::TLB_ENTRIES_DEF,
    parameter int VPN_BITS    = tlbl_pkg::VPN_BITS_DEF,
    parameter int PFN_BITS    = tlbl_pkg::PFN_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        opcode,
    input  wire logic [VPN_BITS-1:0]         virt_page,
    input  wire logic [PFN_BITS-1:0]         phys_frame,
    output logic                             done,
    output logic                             hit,
    output logic [PFN_BITS-1:0]              frame_out,
    output logic [tlbl_pkg::SLOT_W-1:0]      slot_used
);
    import tlbl_pkg::*;

    localparam int QW = 1 + VPN_BITS + PFN_BITS;

    logic          push;
    logic [QW-1:0] push_data;
    logic          pop;
    logic [QW-1:0] pop_data;
    q_stat_t       q_stat;

    tlbl_front #(
        .VPN_BITS (VPN_BITS),
        .PFN_BITS (PFN_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .virt_page  (virt_page),
        .phys_frame (phys_frame),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    tlbl_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    tlbl_back #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .VPN_BITS    (VPN_BITS),
        .PFN_BITS    (PFN_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (pop_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .done      (done),
        .hit       (hit),
        .frame_out (frame_out),
        .slot_used (slot_used)
    );

endmodule
`default_nettype wire
